// ----- hw/rtl/egbw_pkg.sv -----
// egbw_pkg: shared types, codes and constants of the exp-golomb bit writer
// no dependencies

package egbw_pkg;

  // operation codes on the func field
  typedef enum logic [2:0] {
    FUNC_FIXED = 3'd0,
    FUNC_UE    = 3'd1,
    FUNC_SE    = 3'd2,
    FUNC_TRAIL = 3'd3,
    FUNC_FLUSH = 3'd4
  } func_e;

  localparam int unsigned COUNT_BITS_DEF  = 16;
  localparam int unsigned CODE_W          = 33;   // widest code number, 2^32 + 1
  localparam int unsigned LEN_W           = 7;    // codeword length 0..65
  localparam int unsigned FIXED_MAX       = 32;
  localparam logic [15:0] BUF_SIZE_RESET  = 16'd1024;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // one classified item: codeword right-aligned, its length, pad flag
  typedef struct packed {
    logic [CODE_W-1:0] bits;
    logic [LEN_W-1:0]  len;
    logic              pad;
  } entry_t;

endpackage

// ----- hw/rtl/egbw_front.sv -----
// egbw_front: accepts items, builds code numbers and codeword lengths
// depends on egbw_pkg

module egbw_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           func_i,
  input  logic [5:0]           num_bits_i,
  input  logic [31:0]          value_i,
  output logic                 push_valid_o,
  input  logic                 push_ready_i,
  output egbw_pkg::entry_t     push_entry_o
);

  // highest set bit position of a code number
  function automatic logic [5:0] top_bit(input logic [egbw_pkg::CODE_W-1:0] c);
    logic [5:0] t;
    t = '0;
    for (int i = 0; i < egbw_pkg::CODE_W; i++) begin
      if (c[i]) t = 6'(i);
    end
    return t;
  endfunction

  logic                        st_valid_q;
  logic [egbw_pkg::CODE_W-1:0] st_bits_q, st_bits_d;
  logic [egbw_pkg::LEN_W-1:0]  st_len_q, st_len_d;
  logic                        st_eg_q, st_eg_d;
  logic                        st_pad_q, st_pad_d;

  logic [5:0]                  nb_clip;
  logic [egbw_pkg::CODE_W-1:0] fix_mask;
  logic [31:0]                 mag;
  logic [5:0]                  top;
  logic                        drop;
  logic                        st_free;
  logic                        take;

  // classify the incoming item
  always_comb begin
    nb_clip  = (num_bits_i > 6'(egbw_pkg::FIXED_MAX)) ? 6'(egbw_pkg::FIXED_MAX) : num_bits_i;
    fix_mask = (egbw_pkg::CODE_W'(1) << nb_clip) - egbw_pkg::CODE_W'(1);
    mag      = ~value_i + 32'd1;
    st_bits_d = '0;
    st_len_d  = '0;
    st_eg_d   = 1'b0;
    st_pad_d  = 1'b0;
    case (func_i)
      egbw_pkg::FUNC_FIXED: begin
        st_bits_d = {1'b0, value_i} & fix_mask;
        st_len_d  = egbw_pkg::LEN_W'(nb_clip);
      end
      egbw_pkg::FUNC_UE: begin
        st_bits_d = {1'b0, value_i} + egbw_pkg::CODE_W'(1);
        st_eg_d   = 1'b1;
      end
      egbw_pkg::FUNC_SE: begin
        // code number is the mapped value plus one
        if (value_i[31]) begin
          st_bits_d = {mag, 1'b1};
        end else if (value_i == '0) begin
          st_bits_d = egbw_pkg::CODE_W'(1);
        end else begin
          st_bits_d = {value_i, 1'b0};
        end
        st_eg_d = 1'b1;
      end
      egbw_pkg::FUNC_TRAIL: begin
        st_bits_d = egbw_pkg::CODE_W'(1);
        st_len_d  = egbw_pkg::LEN_W'(1);
        st_pad_d  = 1'b1;
      end
      egbw_pkg::FUNC_FLUSH: begin
        st_pad_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // second step: codeword length and hand-off
  always_comb begin
    top  = top_bit(st_bits_q);
    drop = !st_eg_q && (st_len_q == '0) && !st_pad_q;
    push_entry_o.bits = st_bits_q;
    push_entry_o.len  = st_eg_q ? {top, 1'b1} : st_len_q;
    push_entry_o.pad  = st_pad_q;
    push_valid_o = st_valid_q && !drop;
    st_free      = !st_valid_q || drop || push_ready_i;
    in_ready_o   = st_free;
    take         = in_valid_i && st_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= 1'b0;
    end else if (st_free) begin
      st_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      st_bits_q <= st_bits_d;
      st_len_q  <= st_len_d;
      st_eg_q   <= st_eg_d;
      st_pad_q  <= st_pad_d;
    end
  end

endmodule

// ----- hw/rtl/egbw_fifo.sv -----
// egbw_fifo: short queue of classified entries between front and back
// depends on egbw_pkg

module egbw_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  egbw_pkg::entry_t  push_entry_i,
  output logic              head_valid_o,
  input  logic              pop_i,
  output egbw_pkg::entry_t  head_entry_o
);

  localparam int unsigned PTR_W = (egbw_pkg::QUEUE_DEPTH > 1) ? $clog2(egbw_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(egbw_pkg::QUEUE_DEPTH + 1);

  egbw_pkg::entry_t   mem_q [egbw_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  always_comb begin
    push_ready_o = (count_q != CNT_W'(egbw_pkg::QUEUE_DEPTH));
    head_valid_o = (count_q != '0);
    head_entry_o = mem_q[rd_ptr_q];
    do_push = push_valid_i && push_ready_o;
    do_pop  = pop_i && head_valid_o;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(egbw_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(egbw_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

// ----- hw/rtl/egbw_back.sv -----
// egbw_back: packs queued codewords into bytes, tracks count and overflow
// depends on egbw_pkg

module egbw_back #(
  parameter int unsigned COUNT_BITS = egbw_pkg::COUNT_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [15:0]       buffer_size_i,
  input  logic              head_valid_i,
  input  egbw_pkg::entry_t  head_entry_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              last_o,
  output logic              overflow_flag_o
);

  localparam int unsigned CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  logic [6:0]                  pend_q, pend_d;
  logic [2:0]                  pc_q, pc_d;
  logic                        started_q, started_d;
  logic [egbw_pkg::LEN_W-1:0]  rem_q, rem_d;
  logic [COUNT_BITS-1:0]       bytes_done_q, bytes_done_d;
  logic                        overflowed_q, overflowed_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q, out_byte_d;
  logic                        last_q, last_d;
  logic                        ovf_flag_q, ovf_flag_d;

  logic [3:0]                  avail;
  logic [egbw_pkg::LEN_W-1:0]  cur_rem;
  logic [3:0]                  k;
  logic [egbw_pkg::LEN_W-1:0]  rem_after;
  logic [egbw_pkg::CODE_W-1:0] shifted;
  logic [7:0]                  chunk;
  logic [7:0]                  acc;
  logic [3:0]                  newpc;
  logic                        full;
  logic                        done;
  logic                        pad_emit;
  logic                        emit;
  logic                        out_free;
  logic                        step;
  logic                        fits;

  always_comb begin
    avail   = 4'd8 - {1'b0, pc_q};
    cur_rem = started_q ? rem_q : head_entry_i.len;
    k       = (cur_rem < egbw_pkg::LEN_W'(avail)) ? 4'(cur_rem) : avail;
    rem_after = cur_rem - egbw_pkg::LEN_W'(k);
    // next k codeword bits, msb first
    shifted = head_entry_i.bits >> rem_after;
    chunk   = 8'(shifted) & 8'((9'd1 << k) - 9'd1);
    acc     = 8'(({1'b0, pend_q} << k) | chunk);
    newpc   = {1'b0, pc_q} + k;
    full    = (newpc == 4'd8);
    done    = (rem_after == '0);
    pad_emit = done && head_entry_i.pad && !full && (newpc != 4'd0);
    emit     = full || pad_emit;
    out_free = !out_valid_q || out_ready_i;
    step     = head_valid_i && (!emit || out_free);
    pop_o    = step && done;

    fits = !overflowed_q
        && (CMP_W'(bytes_done_q) < CMP_W'(buffer_size_i))
        && (bytes_done_q != {COUNT_BITS{1'b1}});

    pend_d       = pend_q;
    pc_d         = pc_q;
    started_d    = started_q;
    rem_d        = rem_q;
    bytes_done_d = bytes_done_q;
    overflowed_d = overflowed_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    last_d       = last_q;
    ovf_flag_d   = ovf_flag_q;

    if (step) begin
      pend_d    = emit ? 7'd0 : acc[6:0];
      pc_d      = emit ? 3'd0 : newpc[2:0];
      started_d = !done;
      rem_d     = rem_after;
      if (emit) begin
        out_valid_d = 1'b1;
        // last when the rest of the codeword completes no further byte
        last_d      = (rem_after < egbw_pkg::LEN_W'(8)) && (done || !head_entry_i.pad);
        if (fits) begin
          bytes_done_d = bytes_done_q + COUNT_BITS'(1);
          out_byte_d   = full ? acc : 8'(acc << (4'd8 - newpc));
          ovf_flag_d   = 1'b0;
        end else begin
          overflowed_d = 1'b1;
          out_byte_d   = 8'd0;
          ovf_flag_d   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      pc_q         <= '0;
      started_q    <= 1'b0;
      rem_q        <= '0;
      bytes_done_q <= '0;
      overflowed_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_q       <= pend_d;
      pc_q         <= pc_d;
      started_q    <= started_d;
      rem_q        <= rem_d;
      bytes_done_q <= bytes_done_d;
      overflowed_q <= overflowed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    ovf_flag_q <= ovf_flag_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign last_o          = last_q;
  assign overflow_flag_o = ovf_flag_q;

  // overflow is sticky until reset
  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |=> overflowed_q)
    else $error("overflow flag cleared without reset");

  // a dropped byte is reported as zero
  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && ovf_flag_q) |-> (out_byte_q == 8'd0))
    else $error("dropped byte carries data");

  // a partly packed codeword keeps its queue entry
  a_started_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    started_q |-> head_valid_i)
    else $error("codeword in progress lost its queue entry");

  // no bits are held right after a byte goes out
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (pend_q == 7'd0 && pc_q == 3'd0) || !$past(step))
    else $error("pending bits left after a byte was emitted");

endmodule

// ----- hw/rtl/exp_golomb_bit_writer.sv -----
// exp_golomb_bit_writer: top level of the exp-golomb bit writer
// depends on egbw_pkg, egbw_front, egbw_fifo, egbw_back
//
// usage
//   input channel (in_valid_i / in_ready_o) takes one request per cycle while in_ready_o is high:
//   func_i selects fixed write, ue(v), se(v), trailing bits or flush,
//   num_bits_i is the fixed width (above 32 counts as 32), value_i the data
//   output channel (out_valid_o / out_ready_i) carries one stream byte per
//   transfer, msb first; last_o marks the final byte of an input request,
//   overflow_flag_o marks a byte that was dropped (out_byte_o is then 0)
//   config channel (cfg_valid_i / cfg_ready_o) writes buffer_size, the
//   number of bytes passed before overflow; always ready, write while idle
// timing
//   front: one register stage maps the item; its codeword length is found
//   as it enters a two-entry queue that feeds the packer, which moves up to
//   8 bits per cycle, holding while a full byte waits on the output register;
//   a fixed write of width 0 or an unused func is dropped in the front;
//   with the queue empty the first byte passes the front register, the
//   queue and the packer's output register
// reset clears pending bits, byte count, overflow, and sets buffer_size
// to 1024; a stalled receiver holds the output register, then the queue
// fills and in_ready_o drops; nothing is lost

module exp_golomb_bit_writer #(
  parameter int unsigned COUNT_BITS = egbw_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  func_i,
  input  logic [5:0]  num_bits_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        overflow_flag_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  // byte budget register
  logic [15:0] buffer_size_q;

  // front to queue
  logic              push_valid;
  logic              push_ready;
  egbw_pkg::entry_t  push_entry;

  // queue to packer
  logic              head_valid;
  logic              pop;
  egbw_pkg::entry_t  head_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buffer_size_q <= egbw_pkg::BUF_SIZE_RESET;
    end else if (cfg_valid_i) begin
      buffer_size_q <= cfg_data_i;
    end
  end

  // classify requests and build codewords
  egbw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .num_bits_i   (num_bits_i),
    .value_i      (value_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  // decouples front from packer stalls
  egbw_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_entry_o (head_entry)
  );

  // bit packer, byte count and overflow
  egbw_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buffer_size_i   (buffer_size_q),
    .head_valid_i    (head_valid),
    .head_entry_i    (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .overflow_flag_o (overflow_flag_o)
  );

endmodule

// ----- sim/egbw_checker.sv -----
// egbw_checker: predicts the byte stream of the exp-golomb bit writer, checks each byte
// depends on egbw_pkg; watches the request, stream and buffer size channels of the block
`timescale 1ns / 1ps

module egbw_checker #(
  parameter int unsigned COUNT_BITS = egbw_pkg::COUNT_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  func_i,
  input  logic [5:0]  num_bits_i,
  input  logic [31:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic        overflow_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o,
  output int          byte_count_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } stream_byte_t;

  stream_byte_t           stream_bytes_q[$];
  stream_byte_t           want;
  logic [7:0]             acc_bits   = '0;
  int                     acc_cnt    = 0;
  logic [COUNT_BITS-1:0]  byte_count = '0;
  logic                   sticky_ovf = 1'b0;
  logic [15:0]            size_limit = egbw_pkg::BUF_SIZE_RESET;
  int                     errors     = 0;
  int                     checked    = 0;

  // one completed byte, or a dropped one once the buffer is full
  task automatic push_stream_byte(input logic [7:0] b);
    stream_byte_t e;
    if (!sticky_ovf && byte_count < size_limit && byte_count < COUNT_MAX) begin
      byte_count = byte_count + 1'b1;
      e.data = b;
      e.ovf  = 1'b0;
    end else begin
      sticky_ovf = 1'b1;
      e.data = 8'h00;
      e.ovf  = 1'b1;
    end
    e.last = 1'b0;
    stream_bytes_q.push_back(e);
  endtask

  // low n bits of bits, msb first
  task automatic pack_bits(input logic [63:0] bits, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) begin
      acc_bits = {acc_bits[6:0], bits[i]};
      acc_cnt++;
      if (acc_cnt == 8) begin
        push_stream_byte(acc_bits);
        acc_bits = '0;
        acc_cnt  = 0;
      end
    end
  endtask

  task automatic pad_to_byte();
    logic [7:0] padded;
    if (acc_cnt != 0) begin
      padded = acc_bits << (8 - acc_cnt);
      push_stream_byte(padded);
      acc_bits = '0;
      acc_cnt  = 0;
    end
  endtask

  // ue(v) of a number up to 33 bits: prefix zeros then the code number
  task automatic pack_ue(input logic [63:0] num);
    logic [63:0] code;
    int          top;
    code = num + 64'd1;
    top  = 0;
    while (top < 63 && (code >> (top + 1)) != 64'd0) top++;
    pack_bits(64'd0, top);
    pack_bits(code, top + 1);
  endtask

  task automatic pack_request(input logic [2:0] f, input logic [5:0] nb, input logic [31:0] v);
    int           first;
    int           width;
    logic [31:0]  neg32;
    logic [63:0]  masked;
    stream_byte_t tail;
    first = stream_bytes_q.size();
    case (f)
      egbw_pkg::FUNC_FIXED: begin
        width  = (nb > egbw_pkg::FIXED_MAX) ? int'(egbw_pkg::FIXED_MAX) : int'(nb);
        masked = {32'd0, v} & ((64'd1 << width) - 64'd1);
        pack_bits(masked, width);
      end
      egbw_pkg::FUNC_UE: pack_ue({32'd0, v});
      egbw_pkg::FUNC_SE: begin
        if (v[31]) begin
          // most negative value maps to 2^32, no wrap
          neg32 = ~v + 32'd1;
          pack_ue({32'd0, neg32} << 1);
        end else if (v == 32'd0) begin
          pack_ue(64'd0);
        end else begin
          pack_ue(({32'd0, v} << 1) - 64'd1);
        end
      end
      egbw_pkg::FUNC_TRAIL: begin
        pack_bits(64'd1, 1);
        pad_to_byte();
      end
      egbw_pkg::FUNC_FLUSH: pad_to_byte();
      default: ;
    endcase
    if (stream_bytes_q.size() > first) begin
      tail = stream_bytes_q.pop_back();
      tail.last = 1'b1;
      stream_bytes_q.push_back(tail);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_bytes_q.delete();
      acc_bits   = '0;
      acc_cnt    = 0;
      byte_count = '0;
      sticky_ovf = 1'b0;
      size_limit = egbw_pkg::BUF_SIZE_RESET;
    end else begin
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (stream_bytes_q.size() == 0) begin
          errors++;
          $display("%0t: stray byte: expected none, actual byte %02h last %0b overflow %0b",
                   $time, out_byte_i, last_i, overflow_i);
        end else begin
          want = stream_bytes_q.pop_front();
          if (out_byte_i !== want.data) begin
            errors++;
            $display("%0t: out_byte expected %02h actual %02h", $time, want.data, out_byte_i);
          end
          if (last_i !== want.last) begin
            errors++;
            $display("%0t: last expected %0b actual %0b", $time, want.last, last_i);
          end
          if (overflow_i !== want.ovf) begin
            errors++;
            $display("%0t: overflow_flag expected %0b actual %0b", $time, want.ovf, overflow_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) size_limit = cfg_data_i;
      if (in_valid_i && in_ready_i) pack_request(func_i, num_bits_i, value_i);
    end
    fail_count_o <= errors;
    pending_o    <= stream_bytes_q.size();
    checked_o    <= checked;
    byte_count_o <= int'(byte_count);
  end

endmodule

// ----- sim/tb.sv -----
// tb: top of the exp-golomb bit writer testbench; drives requests, buffer size writes and
// receiver stalls, and gives the verdict; depends on egbw_pkg, egbw_checker and the block
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 300000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 24;      // covers requests in flight that make no byte

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [2:0]  func      = '0;
  logic [5:0]  num_bits  = '0;
  logic [31:0] value     = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        last;
  logic        overflow_flag;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;
  int byte_count;

  int idle_pct  = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int sent      = 0;
  int cycle_cnt = 0;

  exp_golomb_bit_writer dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .num_bits_i      (num_bits),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .out_byte_o      (out_byte),
    .last_o          (last),
    .overflow_flag_o (overflow_flag),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  egbw_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .func_i       (func),
    .num_bits_i   (num_bits),
    .value_i      (value),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .last_i       (last),
    .overflow_i   (overflow_flag),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .byte_count_o (byte_count)
  );

  always #5 clk = ~clk;

  // receiver stalls at random, rate set per phase
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d stream bytes still outstanding", $time, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // present one request; valid stays up from the last request unless the sender idles,
  // so valid is never dropped and raised in the same step
  task automatic send_item(input logic [2:0] f, input logic [5:0] nb, input logic [31:0] v);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    num_bits <= nb;
    value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // sender pauses until every predicted byte has come out, then lets the pipe empty
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // buffer size writes only happen with the block idle
  task automatic write_size(input logic [15:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly codes with mixed magnitudes, some padding requests, a few unused func codes
  task automatic send_random();
    logic [2:0]  f;
    logic [5:0]  nb;
    logic [31:0] v;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 35)      f = egbw_pkg::FUNC_FIXED;
    else if (pick < 60) f = egbw_pkg::FUNC_UE;
    else if (pick < 85) f = egbw_pkg::FUNC_SE;
    else if (pick < 91) f = egbw_pkg::FUNC_TRAIL;
    else if (pick < 96) f = egbw_pkg::FUNC_FLUSH;
    else                f = 3'($urandom_range(7, 5));
    v = $urandom >> $urandom_range(31, 0);
    if ($urandom_range(3) == 0) v = $urandom;
    if (f == egbw_pkg::FUNC_SE && $urandom_range(1) == 1) v = ~v + 32'd1;
    if ($urandom_range(9) == 0) nb = 6'($urandom_range(63, 33));
    else                        nb = 6'($urandom_range(32, 0));
    send_item(f, nb, v);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed part under the reset buffer size
    send_item(egbw_pkg::FUNC_FIXED, 6'd0,  32'hDEADBEEF);   // empty write
    send_item(egbw_pkg::FUNC_FIXED, 6'd32, 32'hFFFFFFFF);
    send_item(egbw_pkg::FUNC_FIXED, 6'd63, 32'hA5A5A5A5);   // wide write clamps to 32
    send_item(egbw_pkg::FUNC_FIXED, 6'd40, 32'h00000000);
    send_item(egbw_pkg::FUNC_FIXED, 6'd1,  32'h00000001);
    send_item(egbw_pkg::FUNC_FIXED, 6'd7,  32'h00000055);   // completes a byte
    send_item(egbw_pkg::FUNC_FIXED, 6'd3,  32'h00000005);   // leaves bits pending
    send_item(egbw_pkg::FUNC_FLUSH, 6'd0,  32'h0);          // pad out pending bits
    send_item(egbw_pkg::FUNC_FLUSH, 6'd0,  32'h0);          // already aligned, nothing
    send_item(egbw_pkg::FUNC_TRAIL, 6'd0,  32'h0);          // aligned stop bit gives 0x80
    send_item(egbw_pkg::FUNC_FIXED, 6'd5,  32'h00000013);
    send_item(egbw_pkg::FUNC_TRAIL, 6'd0,  32'h0);          // stop bit after pending bits
    send_item(egbw_pkg::FUNC_UE,    6'd0,  32'h00000000);
    send_item(egbw_pkg::FUNC_UE,    6'd0,  32'hFFFFFFFF);   // largest ue codeword
    send_item(egbw_pkg::FUNC_UE,    6'd0,  32'hFFFFFFFE);
    send_item(egbw_pkg::FUNC_SE,    6'd0,  32'h00000000);
    send_item(egbw_pkg::FUNC_SE,    6'd0,  32'h00000001);
    send_item(egbw_pkg::FUNC_SE,    6'd0,  32'hFFFFFFFF);
    send_item(egbw_pkg::FUNC_SE,    6'd0,  32'h7FFFFFFF);
    send_item(egbw_pkg::FUNC_SE,    6'd0,  32'h80000000);   // most negative se value
    send_item(3'd5,                 6'd63, 32'hFFFFFFFF);   // unused codes do nothing
    send_item(3'd6,                 6'd8,  32'h12345678);
    send_item(3'd7,                 6'd0,  32'h0);
    send_item(egbw_pkg::FUNC_TRAIL, 6'd0,  32'h0);

    write_size(16'hFFFF);

    // random part: no idling, sender idle, receiver stalls, both
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 77; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      if (p == 2) write_size(16'd3000);
      for (int n = 0; n < 16; n++) begin
        if (n == 8) drain();
        send_random();
      end
    end

    // overflow: limit just above the bytes written so far, then a run that crosses it
    idle_pct  = 26;
    stall_pct = 26;
    drain();
    write_size(16'(byte_count + 6));
    for (int n = 0; n < 4; n++) send_item(egbw_pkg::FUNC_FIXED, 6'd32, $urandom);
    for (int n = 0; n < 4; n++) send_random();

    // smallest size, then the largest, which must not clear the sticky overflow
    write_size(16'd0);
    for (int n = 0; n < 4; n++) send_random();
    write_size(16'hFFFF);
    for (int n = 0; n < 4; n++) send_random();
    send_item(egbw_pkg::FUNC_TRAIL, 6'd0, 32'h0);

    drain();
    $display("covered %0d requests in four idle and stall phases, %0d stream bytes checked",
             sent, checked);
    $display("buffer sizes 1024, 65535, 3000, a tight limit, 0 and 65535 again, with overflow");
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- exp_golomb_bit_writer.f -----
hw/rtl/egbw_pkg.sv
hw/rtl/egbw_front.sv
hw/rtl/egbw_fifo.sv
hw/rtl/egbw_back.sv
hw/rtl/exp_golomb_bit_writer.sv
sim/egbw_checker.sv
sim/tb.sv
